FILE: rtl/knob_scanner_with_hysteresis_macros.svh
// assertion macros for the knob scanner checker
// used by ksh_checker.sv; expects clk and rst_n in scope
`ifndef KNOB_SCANNER_WITH_HYSTERESIS_MACROS_SVH
`define KNOB_SCANNER_WITH_HYSTERESIS_MACROS_SVH

// property checked only out of reset
`define KSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define KSH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ksh_pkg.sv
// shared types and constants for the knob scanner
// no dependencies
`default_nettype none

package ksh_pkg;

  localparam int NUM_KNOBS  = 9;
  localparam int CH_W       = 4;
  localparam int IDX_W      = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
  localparam int SAMPLE_W   = 16;
  localparam int STORE_W    = 15;
  localparam int VALUE_SHIFT = 5;
  localparam int VALUE_W    = 10;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [STORE_W-1:0] HYST_RESET = STORE_W'(8);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_KNOBS - 1);

  // item kinds
  localparam logic KIND_CONV = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_HYST = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_NEG  = 5'b00100,
    S_CMP  = 5'b01000,
    S_READ = 5'b10000
  } state_t;

  typedef struct packed {
    logic [STORE_W-1:0] a;
    logic [STORE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [STORE_W-1:0] res;
    logic               borrow;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/knob_scanner_with_hysteresis.sv
// conversion item: accepted in idle, then steps through the shared subtractor
// (difference, negate when the sample is below the stored value, threshold compare)
// read item: S_READ loads the output register, then one result per cycle while out_ready
// is high, NUM_KNOBS results through one output register; ready again after the last load
// reset (rst_n low, synchronous) clears the store, channel pointer, change flag,
// output valid and sets the threshold to 8
`default_nettype none

module knob_scanner_with_hysteresis
  import ksh_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_kind,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [CH_W-1:0]                 out_channel,
  output logic [VALUE_W-1:0]              out_knob_value,
  output logic                            out_changed,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]              prdata,
  output logic                            pready
);

  state_t              state_r, state_nxt;
  logic [STORE_W-1:0]  thr_r;
  logic [IDX_W-1:0]    cur_ch_r, cur_ch_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                flag_r, flag_nxt;
  logic [STORE_W-1:0]  store_r [NUM_KNOBS];
  logic [STORE_W-1:0]  samp_r;
  logic [STORE_W-1:0]  diff_r, diff_nxt;
  logic                store_we;

  logic                out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]     out_ch_r;
  logic [VALUE_W-1:0]  out_val_r;
  logic                out_chg_r;
  logic                out_last_r;
  logic                out_load;

  logic [IDX_W-1:0]    rd_addr;
  logic [STORE_W-1:0]  rd_data;
  logic                in_fire;
  logic                cfg_wr;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  ksh_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_HYST);
  assign prdata   = (paddr[2] == REG_HYST) ? PDATA_W'(thr_r) : '0;

  // single read port: conversion channel or read walk index
  assign rd_addr  = (state_r == S_READ) ? rd_idx_r : cur_ch_r;
  assign rd_data  = store_r[rd_addr];
  assign out_load = (state_r == S_READ) && (!out_valid_r || out_ready);

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_DIFF: begin
        alu_req.a = samp_r;
        alu_req.b = rd_data;
      end
      S_NEG: begin
        alu_req.a = '0;
        alu_req.b = diff_r;
      end
      S_CMP: begin
        alu_req.a = thr_r;
        alu_req.b = diff_r;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cur_ch_nxt    = cur_ch_r;
    rd_idx_nxt    = rd_idx_r;
    flag_nxt      = flag_r;
    diff_nxt      = diff_r;
    store_we      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_READ) begin
            state_nxt  = S_READ;
            rd_idx_nxt = '0;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        diff_nxt  = alu_rsp.res;
        state_nxt = alu_rsp.borrow ? S_NEG : S_CMP;
      end
      S_NEG: begin
        diff_nxt  = alu_rsp.res;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // borrow from thr - diff means diff is above the threshold
        if (alu_rsp.borrow) begin
          store_we = 1'b1;
          flag_nxt = 1'b1;
        end
        cur_ch_nxt = (cur_ch_r == LAST_IDX) ? '0 : cur_ch_r + 1'b1;
        state_nxt  = S_IDLE;
      end
      S_READ: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            flag_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= HYST_RESET;
      cur_ch_r    <= '0;
      rd_idx_r    <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_KNOBS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_ch_r    <= cur_ch_nxt;
      rd_idx_r    <= rd_idx_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        thr_r <= pwdata[STORE_W-1:0];
      end
      if (store_we) begin
        store_r[cur_ch_r] <= samp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      // negative samples clamp to zero
      samp_r <= in_sample[SAMPLE_W-1] ? '0 : in_sample[STORE_W-1:0];
    end
    diff_r <= diff_nxt;
    if (out_load) begin
      out_ch_r   <= CH_W'(rd_idx_r);
      out_val_r  <= rd_data[STORE_W-1:VALUE_SHIFT];
      out_chg_r  <= flag_r;
      out_last_r <= (rd_idx_r == LAST_IDX);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_ch_r;
  assign out_knob_value = out_val_r;
  assign out_changed    = out_chg_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/ksh_alu.sv
// shared subtractor: a - b with borrow out
// depends on ksh_pkg
`default_nettype none

module ksh_alu
  import ksh_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [STORE_W:0] full;

  assign full       = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.res    = full[STORE_W-1:0];
  assign rsp.borrow = full[STORE_W];

endmodule

`default_nettype wire

FILE: rtl/ksh_checker.sv
// port-level checks for the knob scanner, bound to the top level
// depends on ksh_pkg and knob_scanner_with_hysteresis_macros.svh
`default_nettype none

`include "knob_scanner_with_hysteresis_macros.svh"

module ksh_checker
  import ksh_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [CH_W-1:0]            out_channel,
  input wire logic                       out_last
);

  // a stalled result holds its channel
  `KSH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_channel), "stalled item changed")

  // the run ends on the final channel
  `KSH_ASSERT(a_last_ch, out_valid && out_last |-> out_channel == CH_W'(NUM_KNOBS - 1), "last item on wrong channel")

  // within a run the next channel follows at once
  `KSH_ASSERT(a_run_seq, out_valid && out_ready && !out_last |=> out_valid && out_channel == $past(out_channel) + 1'b1, "read run gap or skip")

  // no new item is taken in the middle of a run
  `KSH_ASSERT(a_run_busy, out_valid && !out_last |-> !in_ready, "item taken during read run")

  // nothing is shown right after reset
  `KSH_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind knob_scanner_with_hysteresis ksh_checker u_ksh_checker (.*);

`default_nettype wire

FILE: test/knob_scan_checker.sv
// knob scanner checker: predicts the per-knob results of each read item and compares them
// depends on ksh_pkg; tracks the threshold by watching configuration writes on the cfg bus
`timescale 1ns / 1ps

module knob_scan_checker
  import ksh_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [CH_W-1:0]            out_channel,
  input  logic [VALUE_W-1:0]         out_knob_value,
  input  logic                       out_changed,
  input  logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  input  logic [PDATA_W-1:0]         prdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         outstanding,
  output int                         results_checked
);

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [VALUE_W-1:0] value;
    logic               changed;
    logic               last;
  } knob_report_t;

  knob_report_t       knob_reports_due[$];
  logic [STORE_W-1:0] threshold;
  logic [STORE_W-1:0] knob_mem [NUM_KNOBS];
  int unsigned        scan_ch;
  logic               change_seen;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  task automatic note_mismatch(input string msg);
    $display("[%0t] knob scan mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // negative samples clamp to zero; only a change strictly above the threshold sticks
  task automatic apply_conversion(input logic signed [SAMPLE_W-1:0] s);
    logic [STORE_W-1:0] level;
    logic [STORE_W-1:0] old;
    logic [STORE_W-1:0] delta;
    level = s[SAMPLE_W-1] ? '0 : s[STORE_W-1:0];
    old   = knob_mem[scan_ch];
    delta = (level > old) ? level - old : old - level;
    if (delta > threshold) begin
      knob_mem[scan_ch] = level;
      change_seen       = 1'b1;
    end
    scan_ch = (scan_ch == NUM_KNOBS - 1) ? 0 : scan_ch + 1;
  endtask

  task automatic queue_knob_reports();
    knob_report_t r;
    for (int i = 0; i < NUM_KNOBS; i++) begin
      r.channel = CH_W'(i);
      r.value   = VALUE_W'(knob_mem[i] >> VALUE_SHIFT);
      r.changed = change_seen;
      r.last    = (i == NUM_KNOBS - 1);
      knob_reports_due.push_back(r);
    end
    change_seen = 1'b0;
  endtask

  always @(posedge clk) begin
    knob_report_t want;
    if (!rst_n) begin
      threshold   = HYST_RESET;
      scan_ch     = 0;
      change_seen = 1'b0;
      for (int i = 0; i < NUM_KNOBS; i++) knob_mem[i] = '0;
      knob_reports_due.delete();
    end else begin
      // results of a read item never leave in the cycle it is taken, so check them first
      if (out_valid && out_ready) begin
        results_checked++;
        if (knob_reports_due.size() == 0) begin
          note_mismatch($sformatf("result for channel %0d with none expected", out_channel));
        end else begin
          want = knob_reports_due.pop_front();
          if (out_channel !== want.channel)
            note_mismatch($sformatf("channel expected %0d got %0d", want.channel, out_channel));
          if (out_knob_value !== want.value)
            note_mismatch($sformatf("knob_value ch %0d expected %0d got %0d",
                                    want.channel, want.value, out_knob_value));
          if (out_changed !== want.changed)
            note_mismatch($sformatf("changed ch %0d expected %0b got %0b",
                                    want.channel, want.changed, out_changed));
          if (out_last !== want.last)
            note_mismatch($sformatf("last ch %0d expected %0b got %0b",
                                    want.channel, want.last, out_last));
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_READ) queue_knob_reports();
        else apply_conversion(in_sample);
      end
      if (psel && penable && pready && paddr[2] == REG_HYST) begin
        if (pwrite) threshold = pwdata[STORE_W-1:0];
        else if (prdata[STORE_W-1:0] !== threshold)
          note_mismatch($sformatf("threshold readback expected %0d got %0d",
                                  threshold, prdata[STORE_W-1:0]));
      end
    end
    outstanding = knob_reports_due.size();
  end

endmodule

FILE: test/knob_scanner_with_hysteresis_tb.sv
// top of the knob scanner testbench: clock, reset, item and register stimulus, verdict
// depends on ksh_pkg, knob_scanner_with_hysteresis and knob_scan_checker
`timescale 1ns / 1ps

module knob_scanner_with_hysteresis_tb;
  import ksh_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 65;
  localparam logic [PADDR_W-1:0] HYST_ADDR  = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_kind = KIND_CONV;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CH_W-1:0]            out_channel;
  logic [VALUE_W-1:0]         out_knob_value;
  logic                       out_changed;
  logic                       out_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  int mismatches;
  int outstanding;
  int results_checked;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int conversions_sent = 0;
  int reads_sent = 0;
  int phase_gap[4]   = '{0, 49, 0, 26};
  int phase_stall[4] = '{0, 0, 49, 26};

  always #5 clk = ~clk;

  knob_scanner_with_hysteresis dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_knob_value(out_knob_value), .out_changed(out_changed), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  knob_scan_checker u_scan_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_knob_value(out_knob_value), .out_changed(out_changed), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding), .results_checked(results_checked)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("knob_scanner_with_hysteresis_tb: done, errors");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  // valid is left high so a following item can go out back to back
  task automatic push_item(input logic kind, input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (kind == KIND_READ) reads_sent++;
    else conversions_sent++;
  endtask

  // write one register, then read it back
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // conversions give no result, so wait after the last result for a conversion to finish
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1:    return SAMPLE_W'($urandom);
      2:       return SAMPLE_W'(16'h8000 | $urandom_range(32767));
      3:       return $urandom_range(1) ? 16'sh7fff : 16'sh0000;
      4:       return SAMPLE_W'($urandom_range(32767));
      default: return SAMPLE_W'($urandom_range(300));
    endcase
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty store, field extremes, clamping, threshold edge, wrap, back to back reads
    push_item(KIND_READ, '0);
    push_item(KIND_CONV, 16'sh7fff);
    push_item(KIND_CONV, 16'sh8000);
    push_item(KIND_CONV, -16'sd1);
    push_item(KIND_CONV, 16'sd8);
    push_item(KIND_CONV, 16'sd9);
    push_item(KIND_CONV, 16'sh5555);
    push_item(KIND_CONV, 16'sh2aaa);
    push_item(KIND_CONV, 16'sd31);
    push_item(KIND_CONV, 16'sd32);
    push_item(KIND_READ, '0);
    push_item(KIND_READ, '0);
    push_item(KIND_CONV, 16'sh7ff7);
    drain();
    program_reg(SPARE_ADDR, 32'h0000_1234);
    program_reg(HYST_ADDR, 32'h0);
    push_item(KIND_CONV, 16'sh7ffe);
    push_item(KIND_CONV, 16'sd0);
    push_item(KIND_READ, '0);
    drain();
    program_reg(HYST_ADDR, 32'h0000_7fff);
    push_item(KIND_CONV, 16'sh7fff);
    push_item(KIND_READ, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      case (ph)
        0:       program_reg(HYST_ADDR, PDATA_W'($urandom_range(40)));
        1:       program_reg(HYST_ADDR, PDATA_W'($urandom_range(32767)));
        2:       program_reg(HYST_ADDR, 32'h1);
        default: program_reg(HYST_ADDR, PDATA_W'($urandom_range(200)));
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(9) == 0) push_item(KIND_READ, SAMPLE_W'($urandom));
        else push_item(KIND_CONV, pick_sample());
      end
      drain();
    end

    $display("knob_scanner_with_hysteresis_tb: %0d conversions and %0d reads sent, %0d results",
             conversions_sent, reads_sent, results_checked);
    $display("  checked across four pacing phases and thresholds from 0 to 32767");
    if (mismatches == 0) begin
      $display("knob_scanner_with_hysteresis_tb: done, clean");
    end else begin
      $display("knob_scanner_with_hysteresis_tb: done, errors");
    end
    $finish;
  end

endmodule
